// ===== hdl/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, register indexes and the CRC-16/MODBUS byte update for the
// command frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam int QueueDepth = 4;
    localparam int CfgIdxW    = 3;
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [7:0] RstHead   = 8'hCC;
    localparam logic [7:0] RstAddr   = 8'h01;
    localparam logic [7:0] RstFixLen = 8'h0A;
    localparam logic [7:0] RstCmd    = 8'h80;
    localparam logic [7:0] RstRetLen = 8'h06;
    localparam logic [7:0] RstTail   = 8'hDD;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FRAME_HEAD    = 3'd0,
        CFG_DEST_ADDRESS  = 3'd1,
        CFG_FIXED_LENGTH  = 3'd2,
        CFG_COMMAND_CODE  = 3'd3,
        CFG_RETURN_LENGTH = 3'd4,
        CFG_FRAME_TAIL    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] channel;
        logic [7:0] baud_code;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_req;

    typedef struct packed {
        logic       has_header;
        logic       has_data;
        logic       has_trailer;
        logic [7:0] channel;
        logic [7:0] baud_code;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        ST_START,
        ST_HEAD,
        ST_ADDR,
        ST_LEN,
        ST_CMD,
        ST_RET,
        ST_CHAN,
        ST_BAUD,
        ST_DATA,
        ST_CRCL,
        ST_CRCH,
        ST_TAIL
    } t_step;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/cfb_front.sv =====
// ----------------------------------------------------------------------------
// cfb_front
// Accepts input requests, tracks frame position and classifies each request
// into header, payload and trailer work for the back end.
// ----------------------------------------------------------------------------
module cfb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cfb_pkg::t_in_req   i_req,
    input  cfb_pkg::t_q_status i_q_status,
    output logic               o_push,
    output cfb_pkg::t_entry    o_entry
);

    logic       r_in_frame, n_in_frame;
    logic [7:0] r_bytes_left, n_bytes_left;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        o_entry.channel     = i_req.channel;
        o_entry.baud_code   = i_req.baud_code;
        o_entry.payload_len = i_req.payload_len;
        o_entry.data_byte   = i_req.data_byte;
        if (!r_in_frame) begin
            o_entry.has_header  = 1'b1;
            o_entry.has_data    = (i_req.payload_len != 8'd0);
            o_entry.has_trailer = (i_req.payload_len <= 8'd1);
            n_in_frame          = (i_req.payload_len > 8'd1);
            n_bytes_left        = i_req.payload_len - 8'd1;
        end else begin
            o_entry.has_header  = 1'b0;
            o_entry.has_data    = 1'b1;
            o_entry.has_trailer = (r_bytes_left == 8'd1);
            n_in_frame          = (r_bytes_left != 8'd1);
            n_bytes_left        = r_bytes_left - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
        end else if (o_push) begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_in_frame ? n_bytes_left : 8'd0;
        end
    end

endmodule

// ===== hdl/cfb_queue.sv =====
// ----------------------------------------------------------------------------
// cfb_queue
// Short FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module cfb_queue #(
    parameter int DEPTH = cfb_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cfb_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output cfb_pkg::t_entry    o_head,
    output cfb_pkg::t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    cfb_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CntFull);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/cfb_back.sv =====
// ----------------------------------------------------------------------------
// cfb_back
// Byte sequencer: holds the configuration registers, walks each queued
// request through header, payload and trailer bytes, runs the CRC and drives
// the output register.
// ----------------------------------------------------------------------------
module cfb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cfb_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [7:0]                    i_cfg_data,
    input  cfb_pkg::t_entry               i_head,
    input  cfb_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cfb_pkg::t_out_req             o_req
);

    logic [7:0] r_head, r_addr, r_fix_len, r_cmd, r_ret_len, r_tail;
    cfb_pkg::t_step r_step, n_step, cur_step;
    logic [15:0] r_crc, n_crc;
    logic        r_valid;
    cfb_pkg::t_out_req r_out, n_out;
    logic        load;
    logic        feed;

    assign load    = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= cfb_pkg::RstHead;
            r_addr    <= cfb_pkg::RstAddr;
            r_fix_len <= cfb_pkg::RstFixLen;
            r_cmd     <= cfb_pkg::RstCmd;
            r_ret_len <= cfb_pkg::RstRetLen;
            r_tail    <= cfb_pkg::RstTail;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfb_pkg::CFG_FRAME_HEAD:    r_head    <= i_cfg_data;
                cfb_pkg::CFG_DEST_ADDRESS:  r_addr    <= i_cfg_data;
                cfb_pkg::CFG_FIXED_LENGTH:  r_fix_len <= i_cfg_data;
                cfb_pkg::CFG_COMMAND_CODE:  r_cmd     <= i_cfg_data;
                cfb_pkg::CFG_RETURN_LENGTH: r_ret_len <= i_cfg_data;
                cfb_pkg::CFG_FRAME_TAIL:    r_tail    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_step == cfb_pkg::ST_START) begin
            cur_step = i_head.has_header ? cfb_pkg::ST_HEAD : cfb_pkg::ST_DATA;
        end else begin
            cur_step = r_step;
        end
        n_out.frame_end = 1'b0;
        n_out.out_byte  = 8'h00;
        n_step          = cur_step;
        o_pop           = 1'b0;
        feed            = 1'b1;
        unique case (cur_step)
            cfb_pkg::ST_HEAD: begin
                n_out.out_byte = r_head;
                n_step         = cfb_pkg::ST_ADDR;
            end
            cfb_pkg::ST_ADDR: begin
                n_out.out_byte = r_addr;
                n_step         = cfb_pkg::ST_LEN;
            end
            cfb_pkg::ST_LEN: begin
                n_out.out_byte = r_fix_len + i_head.payload_len;
                n_step         = cfb_pkg::ST_CMD;
            end
            cfb_pkg::ST_CMD: begin
                n_out.out_byte = r_cmd;
                n_step         = cfb_pkg::ST_RET;
            end
            cfb_pkg::ST_RET: begin
                n_out.out_byte = r_ret_len;
                n_step         = cfb_pkg::ST_CHAN;
            end
            cfb_pkg::ST_CHAN: begin
                n_out.out_byte = i_head.channel;
                n_step         = cfb_pkg::ST_BAUD;
            end
            cfb_pkg::ST_BAUD: begin
                n_out.out_byte = i_head.baud_code;
                n_step         = i_head.has_data ? cfb_pkg::ST_DATA : cfb_pkg::ST_CRCL;
            end
            cfb_pkg::ST_DATA: begin
                n_out.out_byte = i_head.data_byte;
                if (i_head.has_trailer) begin
                    n_step = cfb_pkg::ST_CRCL;
                end else begin
                    n_step = cfb_pkg::ST_START;
                    o_pop  = load;
                end
            end
            cfb_pkg::ST_CRCL: begin
                n_out.out_byte = r_crc[7:0];
                n_step         = cfb_pkg::ST_CRCH;
                feed           = 1'b0;
            end
            cfb_pkg::ST_CRCH: begin
                n_out.out_byte = r_crc[15:8];
                n_step         = cfb_pkg::ST_TAIL;
                feed           = 1'b0;
            end
            cfb_pkg::ST_TAIL: begin
                n_out.out_byte  = r_tail;
                n_out.frame_end = 1'b1;
                n_step          = cfb_pkg::ST_START;
                o_pop           = load;
                feed            = 1'b0;
            end
            default: begin
                n_step = cfb_pkg::ST_START;
                feed   = 1'b0;
            end
        endcase
        if (feed) begin
            n_crc = cfb_pkg::crc16_feed(
                (cur_step == cfb_pkg::ST_HEAD) ? cfb_pkg::CrcInit : r_crc, n_out.out_byte);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= cfb_pkg::ST_START;
            r_valid <= 1'b0;
            r_crc   <= cfb_pkg::CrcInit;
        end else begin
            if (load) begin
                r_step  <= n_step;
                r_crc   <= n_crc;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/crc16_command_frame_builder_top.sv =====
// Requests are queued, then the back end sequencer registers each output byte.
// Throughput: one output byte per cycle while the queue is not empty and the
//   output is not stalled; a frame adds seven header, two CRC and one tail byte.
// A 4-entry queue (QDEPTH) lets requests be accepted while header bytes drain.
// Reset: synchronous, active low; clears frame state, queue and output valid, presets
//   the CRC and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// crc16_command_frame_builder_top
// Builds framed commands with a CRC-16/MODBUS trailer from payload requests.
// ----------------------------------------------------------------------------
module crc16_command_frame_builder_top #(
    parameter int QDEPTH = cfb_pkg::QueueDepth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  cfb_pkg::t_in_req            i_req,
    output logic                        o_valid,
    input  logic                        i_stall,
    output cfb_pkg::t_out_req           o_req,
    input  logic                        i_cfg_we,
    input  logic [cfb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [7:0]                  i_cfg_data
);

    cfb_pkg::t_q_status q_status;
    cfb_pkg::t_entry    push_entry, head_entry;
    logic               push, pop;

    cfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    cfb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    cfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_req      (o_req)
    );

endmodule

// ===== hdl/cfb_checker.sv =====
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks for the command frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module cfb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input cfb_pkg::t_in_req            i_req,
    input logic                        o_valid,
    input logic                        i_stall,
    input cfb_pkg::t_out_req           o_req,
    input logic                        i_cfg_we,
    input logic [cfb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input logic [7:0]                  i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_req))
        else $error("stalled output request changed or dropped");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall set after reset");

    a_stall_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) || !$rose(o_stall) || $past(i_valid && !o_stall))
        else $error("input stall rose without an accepted request");

    a_no_out_from_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) && !i_valid |=> !o_valid)
        else $error("output request appeared without any input");

endmodule

bind crc16_command_frame_builder_top cfb_checker u_cfb_checker (.*);
